// ===== hw/rtl/circular_deque_assert.svh =====
// Assertion macros used by the circular deque top level.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH
`ifndef SYNTHESIS
// expr must hold at every rising clock edge out of reset
`define CDQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("circular_deque: invariant violated");
// cons must hold in the cycle after ante
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("circular_deque: sequence check failed");
`else
`define CDQ_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/cdq_pkg.sv =====
// Package: sizes, opcodes, status codes and cell control type of the deque.
package cdq_pkg;

    localparam int SLOTS  = 16;
    localparam int ELEM_W = 32;
    localparam int NCELL  = SLOTS - 1;
    localparam int CNT_W  = $clog2(SLOTS);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NCELL);

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_back;
        logic pop_back;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/cdq_cell.sv =====
// One deque position: element register, occupied flag, neighbor shifting.
module cdq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdq_pkg::t_cell_ctl i_ctl,
    input  cdq_pkg::t_elem    i_value,
    input  cdq_pkg::t_elem    i_left_data,
    input  logic              i_left_occ,
    input  cdq_pkg::t_elem    i_right_data,
    input  logic              i_right_occ,
    input  cdq_pkg::t_elem    i_tail_acc,
    output cdq_pkg::t_elem    o_tail_acc,
    output cdq_pkg::t_elem    o_data,
    output logic              o_occ
);

    cdq_pkg::t_elem r_data;
    cdq_pkg::t_elem n_data;
    logic           r_occ;
    logic           n_occ;
    logic           is_tail;

    // last occupied position holds the rear element
    assign is_tail    = r_occ & ~i_right_occ;
    assign o_tail_acc = i_tail_acc | (r_data & {cdq_pkg::ELEM_W{is_tail}});
    assign o_data     = r_data;
    assign o_occ      = r_occ;

    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        if (i_ctl.clear) begin
            n_occ = 1'b0;
        end else if (i_ctl.push_front) begin
            n_data = i_left_data;
            n_occ  = i_left_occ;
        end else if (i_ctl.pop_front) begin
            n_data = i_right_data;
            n_occ  = i_right_occ;
        end else if (i_ctl.push_back) begin
            if (!r_occ && i_left_occ) begin
                n_data = i_value;
                n_occ  = 1'b1;
            end
        end else if (i_ctl.pop_back) begin
            if (is_tail) begin
                n_occ = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_data <= n_data;
    end

endmodule

// ===== hw/rtl/cdq_chain.sv =====
// Row of deque cells; cell 0 is the front, occupancy fills from cell 0 up.
module cdq_chain (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cdq_pkg::t_cell_ctl        i_ctl,
    input  cdq_pkg::t_elem            i_value,
    output cdq_pkg::t_elem            o_front_data,
    output cdq_pkg::t_elem            o_rear_data,
    output logic [cdq_pkg::NCELL-1:0] o_occ
);

    cdq_pkg::t_elem data   [cdq_pkg::NCELL];
    logic           occ    [cdq_pkg::NCELL];
    cdq_pkg::t_elem left_d [cdq_pkg::NCELL];
    logic           left_o [cdq_pkg::NCELL];
    cdq_pkg::t_elem right_d[cdq_pkg::NCELL];
    logic           right_o[cdq_pkg::NCELL];
    cdq_pkg::t_elem acc    [cdq_pkg::NCELL+1];

    assign acc[0] = '0;

    for (genvar g = 0; g < cdq_pkg::NCELL; g++) begin : g_cell
        if (g == 0) begin : g_first
            // a push at the front enters here
            assign left_d[g] = i_value;
            assign left_o[g] = 1'b1;
        end else begin : g_mid_l
            assign left_d[g] = data[g-1];
            assign left_o[g] = occ[g-1];
        end
        if (g == cdq_pkg::NCELL - 1) begin : g_last
            assign right_d[g] = '0;
            assign right_o[g] = 1'b0;
        end else begin : g_mid_r
            assign right_d[g] = data[g+1];
            assign right_o[g] = occ[g+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_value      (i_value),
            .i_left_data  (left_d[g]),
            .i_left_occ   (left_o[g]),
            .i_right_data (right_d[g]),
            .i_right_occ  (right_o[g]),
            .i_tail_acc   (acc[g]),
            .o_tail_acc   (acc[g+1]),
            .o_data       (data[g]),
            .o_occ        (occ[g])
        );

        assign o_occ[g] = occ[g];
    end

    assign o_front_data = data[0];
    assign o_rear_data  = acc[cdq_pkg::NCELL];

endmodule

// ===== hw/rtl/circular_deque.sv =====
// Top level of the circular deque: handshake, opcode decode, result register.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one item: i_opcode and i_value.
//   Output channel (o_valid / i_ready) returns one result item per input item:
//   o_status, o_read_value, o_count, o_is_empty, o_is_full.
//   Holds up to SLOTS-1 elements. Elements live in a row of cells: cell 0 is
//   the front, occupancy fills upward, so a front push/pop shifts the whole
//   row by one and a back push/pop touches only the cell at the rear end.
//   The result is registered and shows in the cycle after acceptance.
//   Throughput: one item per cycle while results are taken; the single output register sets this.
//   Receiver stall: o_ready drops while a result waits and i_ready is low;
//   the next item is taken in the same cycle the waiting result is taken.
//   Rejected operations (push when full, pop/peek when empty) report a status
//   and leave the contents untouched; read_value is zero unless an element
//   is returned.
//   Reset (i_rst_n low, synchronous): deque empties, no result is pending.
`include "circular_deque_assert.svh"
module circular_deque (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_opcode,
    input  logic [cdq_pkg::ELEM_W-1:0]    i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [cdq_pkg::ELEM_W-1:0]    o_read_value,
    output logic [cdq_pkg::CNT_W-1:0]     o_count,
    output logic                          o_is_empty,
    output logic                          o_is_full
);

    logic                      in_acc;
    logic                      empty;
    logic                      full;
    cdq_pkg::t_cell_ctl        ctl;
    cdq_pkg::t_elem            front_data;
    cdq_pkg::t_elem            rear_data;
    logic [cdq_pkg::NCELL-1:0] occ;

    logic [cdq_pkg::CNT_W-1:0] r_count;
    logic [cdq_pkg::CNT_W-1:0] n_count;
    logic                      r_valid;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    cdq_pkg::t_elem            r_rd;
    cdq_pkg::t_elem            n_rd;
    logic [cdq_pkg::CNT_W-1:0] r_out_count;

    assign o_ready = ~r_valid | i_ready;
    assign in_acc  = i_valid & o_ready;
    assign empty   = (r_count == '0);
    assign full    = (r_count == cdq_pkg::CNT_MAX);

    // decode: status, element read, cell commands, new count
    always_comb begin
        ctl      = '0;
        n_status = cdq_pkg::ST_DONE;
        n_rd     = '0;
        n_count  = r_count;
        case (i_opcode)
            cdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = cdq_pkg::ST_FULL;
                end else begin
                    ctl.push_back = 1'b1;
                    n_count       = r_count + 1'b1;
                end
            end
            cdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = cdq_pkg::ST_FULL;
                end else begin
                    ctl.push_front = 1'b1;
                    n_count        = r_count + 1'b1;
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    ctl.pop_front = 1'b1;
                    n_rd          = front_data;
                    n_count       = r_count - 1'b1;
                end
            end
            cdq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    ctl.pop_back = 1'b1;
                    n_rd         = rear_data;
                    n_count      = r_count - 1'b1;
                end
            end
            cdq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_rd = front_data;
                end
            end
            cdq_pkg::OP_PEEK_BACK: begin
                if (empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_rd = rear_data;
                end
            end
            cdq_pkg::OP_CLEAR: begin
                ctl.clear = 1'b1;
                n_count   = '0;
            end
            default: begin
                // unused opcode: done, nothing changes
            end
        endcase
        if (!in_acc) begin
            ctl = '0;
        end
    end

    cdq_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_value      (i_value),
        .o_front_data (front_data),
        .o_rear_data  (rear_data),
        .o_occ        (occ)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_status    <= n_status;
            r_rd        <= n_rd;
            r_out_count <= n_count;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rd;
    assign o_count      = r_out_count;
    assign o_is_empty   = (r_out_count == '0);
    assign o_is_full    = (r_out_count == cdq_pkg::CNT_MAX);

    // occupancy row is a thermometer code whose length is the count
    `CDQ_ASSERT_ALWAYS(a_occ_matches_count, i_clk, i_rst_n, $countones(occ) == 32'(r_count))
    `CDQ_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= cdq_pkg::CNT_MAX)
    `CDQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, in_acc && !full && (i_opcode == cdq_pkg::OP_PUSH_BACK || i_opcode == cdq_pkg::OP_PUSH_FRONT), r_count == $past(r_count) + 1'b1)
    `CDQ_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, in_acc && i_opcode == cdq_pkg::OP_CLEAR, occ == '0)

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the circular deque: directed table, then biased random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcode seven has no name in the package; the block must ignore it.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 1100;
    // Budget for the slowest legal run of roughly 1130 items, with the longest idle gaps and receiver stalls.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    // One result item as the block reports it.
    typedef struct packed {
        logic [1:0]                status;
        cdq_pkg::t_elem            read_value;
        logic [cdq_pkg::CNT_W-1:0] count;
        logic                      is_empty;
        logic                      is_full;
    } t_deque_result;

    // One row of directed stimulus; when typed is set, want is checked as written.
    typedef struct packed {
        logic [2:0]     op;
        cdq_pkg::t_elem value;
        logic           typed;
        t_deque_result  want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [2:0]                i_opcode;
    cdq_pkg::t_elem            i_value;
    logic                      o_valid;
    logic                      i_ready;
    logic [1:0]                o_status;
    cdq_pkg::t_elem            o_read_value;
    logic [cdq_pkg::CNT_W-1:0] o_count;
    logic                      o_is_empty;
    logic                      o_is_full;

    circular_deque uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow deque: ring of SLOTS entries, one slot always left empty.
    // head_idx is the empty slot before the oldest entry, tail_idx the newest.
    // ------------------------------------------------------------------
    cdq_pkg::t_elem ring_slots [cdq_pkg::SLOTS];
    int             head_idx;
    int             tail_idx;

    t_deque_result pending_results [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int full_rejects  = 0;
    int empty_rejects = 0;
    int clears_done   = 0;
    int cycle_count   = 0;

    function automatic int ring_next(int idx);
        return (idx == cdq_pkg::SLOTS - 1) ? 0 : idx + 1;
    endfunction

    function automatic int ring_prev(int idx);
        return (idx == 0) ? cdq_pkg::SLOTS - 1 : idx - 1;
    endfunction

    // Applies one operation to the shadow deque and returns what the block must report.
    function automatic t_deque_result deque_apply(logic [2:0] op, cdq_pkg::t_elem val);
        t_deque_result res;
        logic          was_empty;
        logic          was_full;
        int            held;
        was_empty      = (head_idx == tail_idx);
        was_full       = (ring_next(tail_idx) == head_idx);
        res.status     = cdq_pkg::ST_DONE;
        res.read_value = '0;
        case (op)
            cdq_pkg::OP_PUSH_BACK: begin
                if (was_full) begin
                    res.status = cdq_pkg::ST_FULL;
                end else begin
                    tail_idx = ring_next(tail_idx);
                    ring_slots[tail_idx] = val;
                end
            end
            cdq_pkg::OP_PUSH_FRONT: begin
                if (was_full) begin
                    res.status = cdq_pkg::ST_FULL;
                end else begin
                    ring_slots[head_idx] = val;
                    head_idx = ring_prev(head_idx);
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (was_empty) begin
                    res.status = cdq_pkg::ST_EMPTY;
                end else begin
                    head_idx = ring_next(head_idx);
                    res.read_value = ring_slots[head_idx];
                end
            end
            cdq_pkg::OP_POP_BACK: begin
                if (was_empty) begin
                    res.status = cdq_pkg::ST_EMPTY;
                end else begin
                    res.read_value = ring_slots[tail_idx];
                    tail_idx = ring_prev(tail_idx);
                end
            end
            cdq_pkg::OP_PEEK_FRONT: begin
                if (was_empty) res.status = cdq_pkg::ST_EMPTY;
                else           res.read_value = ring_slots[ring_next(head_idx)];
            end
            cdq_pkg::OP_PEEK_BACK: begin
                if (was_empty) res.status = cdq_pkg::ST_EMPTY;
                else           res.read_value = ring_slots[tail_idx];
            end
            cdq_pkg::OP_CLEAR: begin
                head_idx = 0;
                tail_idx = 0;
            end
            default: begin
                // unused opcode: nothing moves
            end
        endcase
        held         = (tail_idx + cdq_pkg::SLOTS - head_idx) % cdq_pkg::SLOTS;
        res.count    = cdq_pkg::CNT_W'(held);
        res.is_empty = (head_idx == tail_idx);
        res.is_full  = (ring_next(tail_idx) == head_idx);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Rows with typed=1 carry a hand-written result;
    // the rest are checked against the shadow deque.
    // ------------------------------------------------------------------
    t_stim_row dir_rows [28] = '{
        // every read-type op on the empty deque after reset is rejected
        '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
          '{cdq_pkg::ST_EMPTY, 32'h0, 4'd0, 1'b1, 1'b0}},
        '{cdq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1,
          '{cdq_pkg::ST_EMPTY, 32'h0, 4'd0, 1'b1, 1'b0}},
        '{cdq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1'b1,
          '{cdq_pkg::ST_EMPTY, 32'h0, 4'd0, 1'b1, 1'b0}},
        '{cdq_pkg::OP_PEEK_BACK,  32'hFFFF_FFFF, 1'b1,
          '{cdq_pkg::ST_EMPTY, 32'h0, 4'd0, 1'b1, 1'b0}},
        // value extremes at both ends
        '{cdq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
          '{cdq_pkg::ST_DONE,  32'h0, 4'd1, 1'b0, 1'b0}},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1'b1,
          '{cdq_pkg::ST_DONE,  32'h0, 4'd2, 1'b0, 1'b0}},
        // fill to capacity, alternating ends so the front index wraps
        '{cdq_pkg::OP_PUSH_BACK,  32'h8000_0000, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_BACK,  32'hA5A5_5A5A, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h5A5A_A5A5, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h8765_4321, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_BACK,  32'hDEAD_BEEF, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h3333_CCCC, 1'b0, '0},
        '{cdq_pkg::OP_PUSH_BACK,  32'hCCCC_3333, 1'b0, '0},
        // full: both pushes rejected, contents untouched
        '{cdq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
          '{cdq_pkg::ST_FULL,  32'h0, cdq_pkg::CNT_MAX, 1'b0, 1'b1}},
        '{cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1'b1,
          '{cdq_pkg::ST_FULL,  32'h0, cdq_pkg::CNT_MAX, 1'b0, 1'b1}},
        '{cdq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
        '{cdq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1'b0, '0},
        '{cdq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0, '0},
        '{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{OP_UNUSED,              32'hFFFF_FFFF, 1'b0, '0},
        // clear from a nonempty deque, then prove it is empty
        '{cdq_pkg::OP_CLEAR,      32'h0000_0000, 1'b1,
          '{cdq_pkg::ST_DONE,  32'h0, 4'd0, 1'b1, 1'b0}},
        '{cdq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1'b1,
          '{cdq_pkg::ST_EMPTY, 32'h0, 4'd0, 1'b1, 1'b0}}
    };

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random idle gaps.
    // Valid stays high across back-to-back items within a burst.
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_op(input t_stim_row row);
        t_deque_result predicted;
        int            gap;
        if (burst_left == 0) begin
            // gap of zero now and then keeps valid high across bursts
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // occasional long burst gives stretches with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_opcode <= row.op;
        i_value  <= row.value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // item accepted at this edge
        predicted = deque_apply(row.op, row.value);
        pending_results.push_back(row.typed ? row.want : predicted);
        items_sent++;
        if (predicted.status == cdq_pkg::ST_FULL)  full_rejects++;
        if (predicted.status == cdq_pkg::ST_EMPTY) empty_rejects++;
        if (row.op == cdq_pkg::OP_CLEAR)           clears_done++;
    endtask

    // Random item: push-heavy, pop-heavy or balanced phases sweep the deque
    // between empty and full; clear and the unused opcode are sprinkled in.
    function automatic t_stim_row random_item(int push_pct);
        t_stim_row row;
        int        pick;
        row       = '0;
        pick      = $urandom_range(0, 9);
        row.value = (pick == 0) ? 32'h0000_0000 :
                    (pick == 1) ? 32'hFFFF_FFFF : cdq_pkg::t_elem'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            row.op = cdq_pkg::OP_CLEAR;
        end else if (pick < 5) begin
            row.op = OP_UNUSED;
        end else if ($urandom_range(0, 99) < push_pct) begin
            row.op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
        end else begin
            case ($urandom_range(0, 3))
                0:       row.op = cdq_pkg::OP_POP_FRONT;
                1:       row.op = cdq_pkg::OP_POP_BACK;
                2:       row.op = cdq_pkg::OP_PEEK_FRONT;
                default: row.op = cdq_pkg::OP_PEEK_BACK;
            endcase
        end
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes mode every so often.
    // ------------------------------------------------------------------
    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       i_ready <= 1'b1;                          // never stall
            1:       i_ready <= ($urandom_range(0, 1) == 1);   // coin flip
            2:       i_ready <= ($urandom_range(0, 4) != 0);   // rare stalls
            default: i_ready <= ((rx_tick % 8) == 0);          // long stalls
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_deque_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result item accepted with no expectation pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",     32'(want.status),     32'(o_status));
                check_field("read_value", want.read_value,      o_read_value);
                check_field("count",      32'(want.count),      32'(o_count));
                check_field("is_empty",   32'(want.is_empty),   32'(o_is_empty));
                check_field("is_full",    32'(want.is_full),    32'(o_is_full));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL circular_deque");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : main_seq
        int sent_random;
        int phase_len;
        int push_pct;

        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_opcode <= cdq_pkg::OP_PUSH_BACK;
        i_value  <= '0;
        i_ready  <= 1'b0;
        head_idx = 0;
        tail_idx = 0;
        foreach (ring_slots[k]) ring_slots[k] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_op(dir_rows[k]);

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 85;   // climb toward full
                1:       push_pct = 15;   // drain toward empty
                default: push_pct = 50;   // wander in the middle
            endcase
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) begin
                send_op(random_item(push_pct));
                sent_random++;
            end
        end

        // last item was accepted at this edge; drop valid and drain results
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items, %0d results checked, in %0d cycles.",
                 items_sent, results_seen, cycle_count);
        $display("Rejected pushes on full: %0d, rejected reads on empty: %0d, clears: %0d.",
                 full_rejects, empty_rejects, clears_done);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS circular_deque");
        end else begin
            $display("FAIL circular_deque");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cell.sv
hw/rtl/cdq_chain.sv
hw/rtl/circular_deque.sv
test/testbench.sv
